[hw/rtl/h2rgb_pkg.sv]
package h2rgb_pkg;

   // Fixed widths of the hue field and of its split into sector and offset.
   localparam int HUE_BITS         = 13;
   localparam int FRAC_BITS        = 10;
   localparam int SECTOR_BITS      = 3;
   localparam int CHANNEL_BITS_DEF = 8;

   // Hue units: sixteenths of a degree.
   localparam int HUE_SECTOR = 960;
   localparam int HUE_FULL   = 5760;

   // Register stages from input register to output register.
   localparam int STAGES = 8;

   typedef logic [SECTOR_BITS-1:0] sector_type;

   // Six 60-degree sectors of the color wheel.
   localparam sector_type SEC_RED_YELLOW   = 3'd0;
   localparam sector_type SEC_YELLOW_GREEN = 3'd1;
   localparam sector_type SEC_GREEN_CYAN   = 3'd2;
   localparam sector_type SEC_CYAN_BLUE    = 3'd3;
   localparam sector_type SEC_BLUE_MAGENTA = 3'd4;
   localparam sector_type SEC_MAGENTA_RED  = 3'd5;

   // Stage advance strobes for the scaled-division unit.
   typedef struct packed {
      logic mult;
      logic scale;
      logic fix;
   } div_adv_type;

endpackage

[hw/rtl/h2rgb_decrement.sv]
// Computes floor((level + 480*M - 1) / (960*M)), M = 2^CHANNEL_BITS - 1, over three
// register stages: a reciprocal estimate, a back-multiply, and a remainder correction
// of at most two. The result is how far q or t falls below the value channel.
module h2rgb_decrement #(
   parameter int CHANNEL_BITS = h2rgb_pkg::CHANNEL_BITS_DEF
) (
   input  logic                                      clock,
   input  h2rgb_pkg::div_adv_type                    adv,
   input  logic [2*CHANNEL_BITS+h2rgb_pkg::FRAC_BITS-1:0] level,
   output logic [CHANNEL_BITS-1:0]                   dec
);

   localparam int CB = CHANNEL_BITS;
   localparam int NW = 2*CB + h2rgb_pkg::FRAC_BITS;
   localparam int DW = CB + h2rgb_pkg::FRAC_BITS;

   localparam longint unsigned MAXV = (64'd1 << CB) - 64'd1;
   localparam longint unsigned DEN  = 64'(h2rgb_pkg::HUE_SECTOR) * MAXV;
   localparam longint unsigned BIAS = DEN / 64'd2 - 64'd1;
   localparam longint unsigned RCP  = (64'd1 << (2*CB + h2rgb_pkg::FRAC_BITS)) / DEN;

   localparam logic [NW-1:0] BIAS_V = NW'(BIAS);
   localparam logic [DW-1:0] DEN_V  = DW'(DEN);
   localparam logic [NW-1:0] DEN1_V = NW'(DEN);
   localparam logic [NW-1:0] DEN2_V = NW'(2*DEN);
   localparam logic [CB:0]   RCP_V  = (CB+1)'(RCP);

   logic [NW-1:0]   num_a_ff, num_a_in;
   logic [CB-1:0]   est_a_ff, est_a_in;
   logic [NW-1:0]   num_b_ff, num_b_in;
   logic [CB-1:0]   est_b_ff, est_b_in;
   logic [NW-1:0]   prod_b_ff, prod_b_in;
   logic [CB-1:0]   dec_ff, dec_in;
   logic [2*CB-1:0] num_hi;
   logic [3*CB:0]   est_full;
   logic [NW-1:0]   rem;
   logic            ge_one;
   logic            ge_two;

   // Estimate stage: the reciprocal product under-estimates the quotient by at most two.
   assign num_a_in = level + BIAS_V;
   assign num_hi   = num_a_in[NW-1:h2rgb_pkg::FRAC_BITS];
   assign est_full = {{(CB+1){1'b0}}, num_hi} * {{(2*CB){1'b0}}, RCP_V};
   assign est_a_in = est_full[3*CB-1:2*CB];

   // Back-multiply stage.
   assign num_b_in  = num_a_ff;
   assign est_b_in  = est_a_ff;
   assign prod_b_in = {{DW{1'b0}}, est_a_ff} * {{CB{1'b0}}, DEN_V};

   // Correction stage: the remainder lies below three divisors.
   assign rem    = num_b_ff - prod_b_ff;
   assign ge_one = (rem >= DEN1_V);
   assign ge_two = (rem >= DEN2_V);
   assign dec_in = est_b_ff + {{(CB-1){1'b0}}, ge_one} + {{(CB-1){1'b0}}, ge_two};

   always_ff @(posedge clock) begin
      if (adv.mult) begin
         num_a_ff <= num_a_in;
         est_a_ff <= est_a_in;
      end
      if (adv.scale) begin
         num_b_ff  <= num_b_in;
         est_b_ff  <= est_b_in;
         prod_b_ff <= prod_b_in;
      end
      if (adv.fix) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

[hw/rtl/hsv_to_rgb_converter.sv]
// HSV to RGB pixel converter. Each beat on the req_ side carries a hue in sixteenths
// of a degree (5760 and above wrap to 0) with saturation and value as CHANNEL_BITS-bit
// fractions where all ones means 1.0; each beat on the rsp_ side carries the matching
// red, green and blue codes, rounded to nearest with ties up, in the same order.
// The block is an eight-stage pipeline that takes one pixel every clock when the
// output is not stalled; its stages run through the sector split, the multiplies and
// the three-step division by 960*(2^CHANNEL_BITS-1).
// Back-pressure on rsp_tready stalls each stage only when the stage after it is full,
// so empty slots in the pipeline still take new pixels while a result waits.
module hsv_to_rgb_converter #(
   parameter int CHANNEL_BITS = h2rgb_pkg::CHANNEL_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: hue, saturation, brightness; zero-filled to whole bytes.
   input  logic [((h2rgb_pkg::HUE_BITS + 2*CHANNEL_BITS + 7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: red, green, blue; zero-filled to whole bytes.
   output logic [((3*CHANNEL_BITS + 7)/8)*8-1:0] rsp_tdata
);

   localparam int CB     = CHANNEL_BITS;
   localparam int HB     = h2rgb_pkg::HUE_BITS;
   localparam int FB     = h2rgb_pkg::FRAC_BITS;
   localparam int NW     = 2*CB + FB;
   localparam int ST     = h2rgb_pkg::STAGES;
   localparam int OUT_W  = ((3*CB + 7)/8)*8;

   localparam logic [CB-1:0] MAXV = {CB{1'b1}};
   localparam logic [CB-1:0] HALF = MAXV >> 1;
   localparam logic [HB-1:0] FULL_V = HB'(h2rgb_pkg::HUE_FULL);
   localparam logic [HB-1:0] BASE1  = HB'(h2rgb_pkg::HUE_SECTOR * 1);
   localparam logic [HB-1:0] BASE2  = HB'(h2rgb_pkg::HUE_SECTOR * 2);
   localparam logic [HB-1:0] BASE3  = HB'(h2rgb_pkg::HUE_SECTOR * 3);
   localparam logic [HB-1:0] BASE4  = HB'(h2rgb_pkg::HUE_SECTOR * 4);
   localparam logic [HB-1:0] BASE5  = HB'(h2rgb_pkg::HUE_SECTOR * 5);
   localparam logic [FB:0]   SECT_V = (FB+1)'(h2rgb_pkg::HUE_SECTOR);

   typedef struct packed {
      h2rgb_pkg::sector_type sector;
      logic [CB-1:0]         bri;
      logic [CB-1:0]         lvl_p;
   } side_type;

   // Pipeline control.
   logic [ST-1:0] valid_ff, valid_in, en;

   // Stage 0: input register.
   logic [HB-1:0] hue0_ff, hue0_in;
   logic [CB-1:0] sat0_ff, sat0_in;
   logic [CB-1:0] bri0_ff, bri0_in;

   // Stage 1: sector split.
   logic [HB-1:0]         hue_ok;
   logic [HB-1:0]         base;
   logic [HB-1:0]         offset;
   h2rgb_pkg::sector_type sector1_ff, sector1_in;
   logic [FB-1:0]         frac1_ff, frac1_in;
   logic [FB:0]           fracc1_ff, fracc1_in;
   logic [CB-1:0]         sat1_ff, bri1_ff;

   // Stage 2: saturation products.
   logic [2*CB-1:0]       u2_ff, u2_in;
   logic [2*CB-1:0]       np2_ff, np2_in;
   h2rgb_pkg::sector_type sector2_ff;
   logic [FB-1:0]         frac2_ff;
   logic [FB:0]           fracc2_ff;
   logic [CB-1:0]         bri2_ff;

   // Stage 3: hue-weighted products and the p level.
   logic [NW:0]           yq_full, yt_full;
   logic [NW-1:0]         yq3_ff, yq3_in;
   logic [NW-1:0]         yt3_ff, yt3_in;
   logic [2*CB-1:0]       psum;
   logic [CB-1:0]         p3_ff, p3_in;
   h2rgb_pkg::sector_type sector3_ff;
   logic [CB-1:0]         bri3_ff;

   // Stages 4 to 6: division units and the side data that travels beside them.
   h2rgb_pkg::div_adv_type adv;
   logic [CB-1:0]          dq, dt;
   side_type               side_ff [3];
   side_type               side_in;

   // Stage 7: output register.
   logic [CB-1:0] lvl_q, lvl_t;
   logic [CB-1:0] red_ff, red_in;
   logic [CB-1:0] green_ff, green_in;
   logic [CB-1:0] blue_ff, blue_in;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      en[ST-1] = !valid_ff[ST-1] || rsp_tready;
      for (int k = ST-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < ST; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input beat unpacking.
   assign hue0_in = req_tdata[HB-1:0];
   assign sat0_in = req_tdata[HB+CB-1:HB];
   assign bri0_in = req_tdata[HB+2*CB-1:HB+CB];

   // Sector and offset inside the sector; hues past the full circle wrap to zero.
   always_comb begin
      hue_ok = (hue0_ff < FULL_V) ? hue0_ff : '0;
      if (hue_ok >= BASE5) begin
         sector1_in = h2rgb_pkg::SEC_MAGENTA_RED;
         base       = BASE5;
      end else if (hue_ok >= BASE4) begin
         sector1_in = h2rgb_pkg::SEC_BLUE_MAGENTA;
         base       = BASE4;
      end else if (hue_ok >= BASE3) begin
         sector1_in = h2rgb_pkg::SEC_CYAN_BLUE;
         base       = BASE3;
      end else if (hue_ok >= BASE2) begin
         sector1_in = h2rgb_pkg::SEC_GREEN_CYAN;
         base       = BASE2;
      end else if (hue_ok >= BASE1) begin
         sector1_in = h2rgb_pkg::SEC_YELLOW_GREEN;
         base       = BASE1;
      end else begin
         sector1_in = h2rgb_pkg::SEC_RED_YELLOW;
         base       = '0;
      end
      offset    = hue_ok - base;
      frac1_in  = offset[FB-1:0];
      fracc1_in = SECT_V - {1'b0, frac1_in};
   end

   // Saturation times value, and the rounded numerator of p.
   assign u2_in  = {{CB{1'b0}}, sat1_ff} * {{CB{1'b0}}, bri1_ff};
   assign np2_in = {{CB{1'b0}}, bri1_ff} * {{CB{1'b0}}, MAXV - sat1_ff}
                   + {{CB{1'b0}}, HALF};

   // Weighting by the hue offset; p is the numerator divided by 2^CB - 1.
   assign yq_full = {{(FB+1){1'b0}}, u2_ff} * {{(2*CB){1'b0}}, 1'b0, frac2_ff};
   assign yt_full = {{(FB+1){1'b0}}, u2_ff} * {{(2*CB){1'b0}}, fracc2_ff};
   assign yq3_in  = yq_full[NW-1:0];
   assign yt3_in  = yt_full[NW-1:0];
   assign psum    = np2_ff + (np2_ff >> CB) + {{(2*CB-1){1'b0}}, 1'b1};
   assign p3_in   = psum[2*CB-1:CB];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hue0_ff <= hue0_in;
         sat0_ff <= sat0_in;
         bri0_ff <= bri0_in;
      end
      if (en[1]) begin
         sector1_ff <= sector1_in;
         frac1_ff   <= frac1_in;
         fracc1_ff  <= fracc1_in;
         sat1_ff    <= sat0_ff;
         bri1_ff    <= bri0_ff;
      end
      if (en[2]) begin
         u2_ff      <= u2_in;
         np2_ff     <= np2_in;
         sector2_ff <= sector1_ff;
         frac2_ff   <= frac1_ff;
         fracc2_ff  <= fracc1_ff;
         bri2_ff    <= bri1_ff;
      end
      if (en[3]) begin
         yq3_ff     <= yq3_in;
         yt3_ff     <= yt3_in;
         p3_ff      <= p3_in;
         sector3_ff <= sector2_ff;
         bri3_ff    <= bri2_ff;
      end
   end

   // Division of the q and t weights by 960*(2^CB - 1).
   assign adv = '{mult: en[4], scale: en[5], fix: en[6]};

   h2rgb_decrement #(
      .CHANNEL_BITS(CB)
   ) u_dec_q (
      .clock(clock),
      .adv  (adv),
      .level(yq3_ff),
      .dec  (dq)
   );

   h2rgb_decrement #(
      .CHANNEL_BITS(CB)
   ) u_dec_t (
      .clock(clock),
      .adv  (adv),
      .level(yt3_ff),
      .dec  (dt)
   );

   // Sector, value and p ride beside the division units.
   assign side_in = '{sector: sector3_ff, bri: bri3_ff, lvl_p: p3_ff};

   always_ff @(posedge clock) begin
      if (en[4]) begin
         side_ff[0] <= side_in;
      end
      if (en[5]) begin
         side_ff[1] <= side_ff[0];
      end
      if (en[6]) begin
         side_ff[2] <= side_ff[1];
      end
   end

   // Six-sector routing of v, t, p and q onto the channels.
   always_comb begin
      lvl_q = side_ff[2].bri - dq;
      lvl_t = side_ff[2].bri - dt;
      case (side_ff[2].sector)
         h2rgb_pkg::SEC_RED_YELLOW: begin
            red_in   = side_ff[2].bri;
            green_in = lvl_t;
            blue_in  = side_ff[2].lvl_p;
         end
         h2rgb_pkg::SEC_YELLOW_GREEN: begin
            red_in   = lvl_q;
            green_in = side_ff[2].bri;
            blue_in  = side_ff[2].lvl_p;
         end
         h2rgb_pkg::SEC_GREEN_CYAN: begin
            red_in   = side_ff[2].lvl_p;
            green_in = side_ff[2].bri;
            blue_in  = lvl_t;
         end
         h2rgb_pkg::SEC_CYAN_BLUE: begin
            red_in   = side_ff[2].lvl_p;
            green_in = lvl_q;
            blue_in  = side_ff[2].bri;
         end
         h2rgb_pkg::SEC_BLUE_MAGENTA: begin
            red_in   = lvl_t;
            green_in = side_ff[2].lvl_p;
            blue_in  = side_ff[2].bri;
         end
         default: begin
            red_in   = side_ff[2].bri;
            green_in = side_ff[2].lvl_p;
            blue_in  = lvl_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[ST-1]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // Output beat packing.
   assign rsp_tvalid = valid_ff[ST-1];
   assign rsp_tdata  = OUT_W'({blue_ff, green_ff, red_ff});

endmodule
